[hdl/prp_pkg.sv]
// prp_pkg.sv: shared constants, payload words, operand struct, Q1.14 sine table
// and quadrant fold for the point rotate / isometric projection pipeline.
// No dependencies.
package prp_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int FRAC_BITS    = 14;   // sine table below is Q1.14
  localparam int ANGLE_W      = 16;
  localparam int FULL_TURN    = 360;
  localparam int HALF_TURN    = 180;
  localparam int QUARTER_TURN = 90;
  localparam int ISO_DEG      = 30;
  localparam int DEG_W        = 9;
  localparam int SIN_IDX_W    = 7;
  localparam int COEF_W       = FRAC_BITS + 2;       // holds +/- 2^FRAC_BITS
  localparam int OPND_W       = COORD_WIDTH + 1;     // x+y, x-y, -z
  localparam int PROD_W       = OPND_W + COEF_W;
  localparam int ACC_W        = PROD_W + 2;
  localparam int NSTAGE       = 6;

  // angle mod 360 by reciprocal multiply on the biased (unsigned) angle
  localparam int QUOT_W      = ANGLE_W - 8;
  localparam int RECIP_SHIFT = ANGLE_W + 9;
  localparam int RECIP_W     = RECIP_SHIFT - 8;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + FULL_TURN - 1) / FULL_TURN;
  localparam int ANGLE_BIAS  = (1 << (ANGLE_W - 1)) % FULL_TURN;

  typedef enum logic [1:0] {
    ACT_ROT_X = 2'd0,
    ACT_ROT_Y = 2'd1,
    ACT_ROT_Z = 2'd2,
    ACT_ISO   = 2'd3
  } action_t;

  typedef struct packed {
    action_t                         action;
    logic signed [ANGLE_W-1:0]       angle_deg;
    logic signed [COORD_WIDTH-1:0]   x_in;
    logic signed [COORD_WIDTH-1:0]   y_in;
    logic signed [COORD_WIDTH-1:0]   z_in;
  } prp_in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0]   x_out;
    logic signed [COORD_WIDTH-1:0]   y_out;
    logic signed [COORD_WIDTH-1:0]   z_out;
  } prp_out_t;

  // one lane: a*ca + b*cb + add*2^FRAC_BITS
  typedef struct packed {
    logic signed [OPND_W-1:0] a;
    logic signed [COEF_W-1:0] ca;
    logic signed [OPND_W-1:0] b;
    logic signed [COEF_W-1:0] cb;
    logic signed [OPND_W-1:0] add;
  } dot_opnd_t;

  // round(sin(d deg) * 2^14), d = 0..90
  function automatic logic signed [COEF_W-1:0] sin_tab(input logic [SIN_IDX_W-1:0] idx);
    int v;
    case (idx)
      0: v = 0;         1: v = 286;       2: v = 572;       3: v = 857;       4: v = 1143;
      5: v = 1428;      6: v = 1713;      7: v = 1997;      8: v = 2280;      9: v = 2563;
      10: v = 2845;     11: v = 3126;     12: v = 3406;     13: v = 3686;     14: v = 3964;
      15: v = 4240;     16: v = 4516;     17: v = 4790;     18: v = 5063;     19: v = 5334;
      20: v = 5604;     21: v = 5872;     22: v = 6138;     23: v = 6402;     24: v = 6664;
      25: v = 6924;     26: v = 7182;     27: v = 7438;     28: v = 7692;     29: v = 7943;
      30: v = 8192;     31: v = 8438;     32: v = 8682;     33: v = 8923;     34: v = 9162;
      35: v = 9397;     36: v = 9630;     37: v = 9860;     38: v = 10087;    39: v = 10311;
      40: v = 10531;    41: v = 10749;    42: v = 10963;    43: v = 11174;    44: v = 11381;
      45: v = 11585;    46: v = 11786;    47: v = 11982;    48: v = 12176;    49: v = 12365;
      50: v = 12551;    51: v = 12733;    52: v = 12911;    53: v = 13085;    54: v = 13255;
      55: v = 13421;    56: v = 13583;    57: v = 13741;    58: v = 13894;    59: v = 14044;
      60: v = 14189;    61: v = 14330;    62: v = 14466;    63: v = 14598;    64: v = 14726;
      65: v = 14849;    66: v = 14968;    67: v = 15082;    68: v = 15191;    69: v = 15296;
      70: v = 15396;    71: v = 15491;    72: v = 15582;    73: v = 15668;    74: v = 15749;
      75: v = 15826;    76: v = 15897;    77: v = 15964;    78: v = 16026;    79: v = 16083;
      80: v = 16135;    81: v = 16182;    82: v = 16225;    83: v = 16262;    84: v = 16294;
      85: v = 16322;    86: v = 16344;    87: v = 16362;    88: v = 16374;    89: v = 16382;
      90: v = 16384;
      default: v = 0;
    endcase
    return COEF_W'(v);
  endfunction

  // sine of 0..359 degrees by quadrant symmetry
  function automatic logic signed [COEF_W-1:0] rom_sin(input logic [DEG_W-1:0] deg);
    logic [DEG_W-1:0] fold;
    logic             neg;
    if (deg <= DEG_W'(QUARTER_TURN)) begin
      fold = deg;
      neg  = 1'b0;
    end else if (deg <= DEG_W'(HALF_TURN)) begin
      fold = DEG_W'(HALF_TURN) - deg;
      neg  = 1'b0;
    end else if (deg <= DEG_W'(HALF_TURN + QUARTER_TURN)) begin
      fold = deg - DEG_W'(HALF_TURN);
      neg  = 1'b1;
    end else begin
      fold = DEG_W'(FULL_TURN) - deg;
      neg  = 1'b1;
    end
    return neg ? -sin_tab(SIN_IDX_W'(fold)) : sin_tab(SIN_IDX_W'(fold));
  endfunction

  localparam logic signed [COEF_W-1:0] ISO_SIN = sin_tab(SIN_IDX_W'(ISO_DEG));
  localparam logic signed [COEF_W-1:0] ISO_COS = sin_tab(SIN_IDX_W'(QUARTER_TURN - ISO_DEG));

endpackage

[hdl/prp_angle.sv]
// prp_angle.sv: three-stage angle path: biased reciprocal multiply, mod 360
// correction, sine/cosine table lookup. Depends on prp_pkg.
module prp_angle (
  input  logic                                 clk,
  input  logic [2:0]                           en,
  input  logic signed [prp_pkg::ANGLE_W-1:0]   angle_deg,
  output logic signed [prp_pkg::COEF_W-1:0]    sin_q,
  output logic signed [prp_pkg::COEF_W-1:0]    cos_q
);
  import prp_pkg::*;

  logic [ANGLE_W-1:0]         ubias;
  logic [ANGLE_W+RECIP_W-1:0] prod;
  logic [ANGLE_W-1:0]         u1_r;
  logic [QUOT_W-1:0]          q1_r;
  logic [ANGLE_W-1:0]         rem;
  logic [DEG_W-1:0]           rem_deg;
  logic [DEG_W-1:0]           deg_nxt;
  logic [DEG_W-1:0]           deg2_r;
  logic [DEG_W-1:0]           cdeg;
  logic signed [COEF_W-1:0]   sin3_r;
  logic signed [COEF_W-1:0]   cos3_r;

  // angle + 2^15 as unsigned; quotient by 360 via reciprocal
  assign ubias = {~angle_deg[ANGLE_W-1], angle_deg[ANGLE_W-2:0]};
  assign prod  = (ANGLE_W+RECIP_W)'(ubias) * (ANGLE_W+RECIP_W)'(RECIP);

  // remainder, then remove the bias (2^15 mod 360)
  assign rem     = u1_r - ANGLE_W'(q1_r) * ANGLE_W'(FULL_TURN);
  assign rem_deg = rem[DEG_W-1:0];
  assign deg_nxt = (rem_deg < DEG_W'(ANGLE_BIAS)) ?
                   rem_deg + DEG_W'(FULL_TURN - ANGLE_BIAS) :
                   rem_deg - DEG_W'(ANGLE_BIAS);

  assign cdeg = (deg2_r >= DEG_W'(FULL_TURN - QUARTER_TURN)) ?
                deg2_r - DEG_W'(FULL_TURN - QUARTER_TURN) :
                deg2_r + DEG_W'(QUARTER_TURN);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      u1_r <= ubias;
      q1_r <= prod[RECIP_SHIFT +: QUOT_W];
    end
    if (en[1]) begin
      deg2_r <= deg_nxt;
    end
    if (en[2]) begin
      sin3_r <= rom_sin(deg2_r);
      cos3_r <= rom_sin(cdeg);
    end
  end

  assign sin_q = sin3_r;
  assign cos_q = cos3_r;

endmodule

[hdl/prp_dot.sv]
// prp_dot.sv: one output lane: two products, sum with scaled addend, then
// truncate toward zero and saturate. Three stages. Depends on prp_pkg.
module prp_dot (
  input  logic                                    clk,
  input  logic [2:0]                              en,
  input  prp_pkg::dot_opnd_t                      opnd,
  output logic signed [prp_pkg::COORD_WIDTH-1:0]  res
);
  import prp_pkg::*;

  localparam int QW = ACC_W - FRAC_BITS;
  localparam logic signed [QW-1:0] SAT_MAX =
    {{(QW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [QW-1:0] SAT_MIN = ~SAT_MAX;

  logic signed [PROD_W-1:0]      pa_r;
  logic signed [PROD_W-1:0]      pb_r;
  logic signed [OPND_W-1:0]      add4_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [QW-1:0]          qfl;
  logic                          rnd;
  logic signed [QW-1:0]          qt;
  logic signed [COORD_WIDTH-1:0] res_nxt;
  logic signed [COORD_WIDTH-1:0] res_r;

  // floor, plus one when negative with a nonzero fraction
  assign qfl = acc_r[ACC_W-1:FRAC_BITS];
  assign rnd = acc_r[ACC_W-1] && (|acc_r[FRAC_BITS-1:0]);
  assign qt  = qfl + $signed({{(QW-1){1'b0}}, rnd});

  always_comb begin
    if (qt > SAT_MAX) begin
      res_nxt = SAT_MAX[COORD_WIDTH-1:0];
    end else if (qt < SAT_MIN) begin
      res_nxt = SAT_MIN[COORD_WIDTH-1:0];
    end else begin
      res_nxt = qt[COORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pa_r   <= opnd.a * opnd.ca;
      pb_r   <= opnd.b * opnd.cb;
      add4_r <= opnd.add;
    end
    if (en[1]) begin
      acc_r <= ACC_W'(pa_r) + ACC_W'(pb_r) + (ACC_W'(add4_r) <<< FRAC_BITS);
    end
    if (en[2]) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

[hdl/point_rotate_project_3d.sv]
// point_rotate_project_3d.sv: top level of the 3D rotate / isometric projection
// pipeline. Depends on prp_pkg, prp_angle and prp_dot.
//
//  channel   ports                           word
//  -------   -----------------------------   ---------------------------------
//  input     in_valid  in_ready  in_data     action, angle_deg, x_in, y_in, z_in
//  result    out_valid out_ready out_data    x_out, y_out, z_out
//
// Six register stages, one word per cycle sustained while out_ready is high;
// stages 1-3 reduce the angle mod 360 (reciprocal multiply) and look up sin/cos;
// stages 4-6 are per-lane multiply, sum, truncate/saturate.
// Reset (rst_n low, synchronous) clears only the stage valid bits.
// Each stage has its own ready: a stall on out_ready only fills bubbles, so
// in_ready stays high while any stage is empty; nothing is dropped or repeated.
module point_rotate_project_3d (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  prp_pkg::prp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output prp_pkg::prp_out_t out_data
);
  import prp_pkg::*;

  logic [NSTAGE-1:0]             vld_r;
  logic [NSTAGE-1:0]             vld_nxt;
  logic [NSTAGE-1:0]             rdy;
  prp_in_t                       word1_r;
  prp_in_t                       word2_r;
  prp_in_t                       word3_r;
  logic signed [COEF_W-1:0]      sin3;
  logic signed [COEF_W-1:0]      cos3;
  logic signed [OPND_W-1:0]      xe;
  logic signed [OPND_W-1:0]      ye;
  logic signed [OPND_W-1:0]      ze;
  dot_opnd_t                     opx;
  dot_opnd_t                     opy;
  dot_opnd_t                     opz;
  logic signed [COORD_WIDTH-1:0] xres;
  logic signed [COORD_WIDTH-1:0] yres;
  logic signed [COORD_WIDTH-1:0] zres;
  logic                          in_fire;
  logic                          out_fire;

  // per-stage ready: a stage may load when empty or when it is draining
  always_comb begin
    rdy[NSTAGE-1] = !vld_r[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (rdy[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < NSTAGE; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // point and action ride along with the angle path
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      word1_r <= in_data;
    end
    if (rdy[1]) begin
      word2_r <= word1_r;
    end
    if (rdy[2]) begin
      word3_r <= word2_r;
    end
  end

  prp_angle u_angle (
    .clk       (clk),
    .en        (rdy[2:0]),
    .angle_deg (in_data.angle_deg),
    .sin_q     (sin3),
    .cos_q     (cos3)
  );

  assign xe = OPND_W'(word3_r.x_in);
  assign ye = OPND_W'(word3_r.y_in);
  assign ze = OPND_W'(word3_r.z_in);

  // lane operands; an untouched coordinate goes through as the addend
  always_comb begin
    opx = '{a: '0, ca: '0, b: '0, cb: '0, add: xe};
    opy = '{a: '0, ca: '0, b: '0, cb: '0, add: ye};
    opz = '{a: '0, ca: '0, b: '0, cb: '0, add: ze};
    case (word3_r.action)
      ACT_ROT_X: begin
        opy = '{a: ye, ca: cos3, b: ze, cb: -sin3, add: '0};
        opz = '{a: ye, ca: sin3, b: ze, cb: cos3, add: '0};
      end
      ACT_ROT_Y: begin
        opx = '{a: xe, ca: cos3, b: ze, cb: sin3, add: '0};
        opz = '{a: xe, ca: -sin3, b: ze, cb: cos3, add: '0};
      end
      ACT_ROT_Z: begin
        opx = '{a: xe, ca: cos3, b: ye, cb: -sin3, add: '0};
        opy = '{a: xe, ca: sin3, b: ye, cb: cos3, add: '0};
      end
      ACT_ISO: begin
        // fixed 30 deg projection; y picks up the incoming z (altitude)
        opx = '{a: xe - ye, ca: ISO_COS, b: '0, cb: '0, add: '0};
        opy = '{a: xe + ye, ca: ISO_SIN, b: '0, cb: '0, add: -ze};
      end
      default: begin
      end
    endcase
  end

  prp_dot u_dot_x (
    .clk  (clk),
    .en   (rdy[5:3]),
    .opnd (opx),
    .res  (xres)
  );

  prp_dot u_dot_y (
    .clk  (clk),
    .en   (rdy[5:3]),
    .opnd (opy),
    .res  (yres)
  );

  prp_dot u_dot_z (
    .clk  (clk),
    .en   (rdy[5:3]),
    .opnd (opz),
    .res  (zres)
  );

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NSTAGE-1];
  assign out_data  = '{x_out: xres, y_out: yres, z_out: zres};
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

`ifndef SYNTHESIS
  a_room_means_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r != {NSTAGE{1'b1}}) |-> in_ready)
    else $error("in_ready low with an empty stage");

  a_word_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire == out_fire) |=> ($countones(vld_r) == $past($countones(vld_r))))
    else $error("words in flight changed without matching accept");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NSTAGE-2] && !rdy[NSTAGE-1]) |=> (vld_r[NSTAGE-2] && vld_r[NSTAGE-1]))
    else $error("stalled word lost near output");
`endif

endmodule
